/* hw/rtl/hnps_pkg.sv */
// Package: shared types, codes and constants for the held-note priority stack.
`default_nettype none

package hnps_pkg;

  // Default number of stack slots
  localparam int DEFAULT_DEPTH = 16;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int HCNT_W  = 5;
  localparam int S_DATA_W = 16;  // note + velocity, padded to bytes
  localparam int M_DATA_W = 24;  // count + flag + note + velocity, padded

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MATCH,
    ST_ISO,
    ST_MASK,
    ST_SHIFT,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming beat
    logic clear;     // empty the stack
    logic match;     // register per-slot match flags
    logic iso;       // isolate the oldest matching slot
    logic mask;      // build the gap-closing mask
    logic shift;     // close the gap over the matched slot
    logic push;      // place the note on top
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    req_t req;       // captured request
    logic out_busy;  // output register holds a beat not yet taken
  } stat_t;

endpackage : hnps_pkg

`default_nettype wire

/* hw/rtl/hnps_datapath.sv */
// Datapath: key slots, count, match and mask registers, and output register.
`default_nettype none

module hnps_datapath
  import hnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic [REQ_W-1:0]    in_req,
  input  wire logic [NOTE_W-1:0]   in_note,
  input  wire logic [VEL_W-1:0]    in_vel,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [HCNT_W-1:0]        out_count,
  output logic                     out_any,
  output logic [NOTE_W-1:0]        out_note,
  output logic [VEL_W-1:0]         out_vel
);

  localparam int D  = STACK_DEPTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Slot 0 holds the newest key, slot count-1 the oldest
  logic [NOTE_W-1:0] key_notes [D];
  logic [VEL_W-1:0]  key_vels  [D];
  logic [CW-1:0]     count;

  logic [REQ_W-1:0]  req;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  vel;

  logic [D-1:0]      match;     // slot j is live and holds the note
  logic [D-1:0]      low;       // oldest match, in reversed bit order
  logic [D-1:0]      mask;      // slots that take the next one up
  logic              found;

  logic [D-1:0]      match_rev;
  logic [D-1:0]      match_next;
  logic [D-1:0]      mask_rev;
  logic              any_live;

  assign stat.req      = req_t'(req);
  assign stat.out_busy = out_valid;
  assign any_live      = (count != '0);

  // Compare every live slot against the note
  always_comb begin
    for (int j = 0; j < D; j++) begin
      match_next[j] = (key_notes[j] == note) && (CW'(j) < count);
      match_rev[j]  = match[D-1-j];
    end
  end

  // Ones up to and including the isolated bit, reversed back
  always_comb begin
    logic [D-1:0] pre;
    pre = low | (low - 1'b1);
    for (int j = 0; j < D; j++) begin
      mask_rev[j] = pre[D-1-j];
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= in_req;
      note <= in_note;
      vel  <= in_vel;
    end
  end

  // Match, isolate and mask stages
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match <= match_next;
    end
    if (cmd.iso) begin
      low   <= match_rev & (~match_rev + 1'b1);
      found <= |match;
    end
    if (cmd.mask) begin
      mask <= found ? mask_rev : '0;
    end
  end

  // Slot storage: close the gap or push a new key on top
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int j = 0; j < D - 1; j++) begin
        if (mask[j]) begin
          key_notes[j] <= key_notes[j+1];
          key_vels[j]  <= key_vels[j+1];
        end
      end
    end else if (cmd.push) begin
      key_notes[0] <= note;
      key_vels[0]  <= vel;
      for (int j = 1; j < D; j++) begin
        key_notes[j] <= key_notes[j-1];
        key_vels[j]  <= key_vels[j-1];
      end
    end
  end

  // Count of held keys
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.shift && found) begin
      count <= count - 1'b1;
    end else if (cmd.push && (count != CW'(D))) begin
      count <= count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count <= HCNT_W'(count);
      out_any   <= any_live;
      out_note  <= any_live ? key_notes[0] : '0;
      out_vel   <= any_live ? key_vels[0] : '0;
    end
  end

endmodule : hnps_datapath

`default_nettype wire

/* hw/rtl/hnps_ctrl.sv */
// Controller: sequences the match, gap-close and push steps for one beat.
`default_nettype none

module hnps_ctrl
  import hnps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.req)
          REQ_PRESS, REQ_RELEASE: state_next = ST_MATCH;
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = ST_ISO;
      end
      ST_ISO: begin
        cmd.iso    = 1'b1;
        state_next = ST_MASK;
      end
      ST_MASK: begin
        cmd.mask   = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = (stat.req == REQ_PRESS) ? ST_PUSH : ST_DONE;
      end
      ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!stat.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule : hnps_ctrl

`default_nettype wire

/* hw/rtl/held_note_priority_stack.sv */
// Top level: last-note priority stack of held keys for a mono synthesizer.
//
// Input channel s_*: one beat per key event. s_tuser carries the request
// (press, release, clear); s_tdata carries note and velocity.
// Output channel m_*: exactly one beat per input beat, in order, giving the
// held count, a held flag and the newest held note and velocity.
// Processing: the controller decodes the accepted request. A press or
// release runs the match compare, oldest-match isolate, mask build and
// gap-close shift steps, and a press then pushes the note on top; a clear
// empties the stack and an unused code goes straight to the result. The
// controller returns to idle before the next beat is taken.
// The output register parts the two sides: a finished result waits there
// while the next beat is accepted and processed. If the receiver stalls,
// the controller holds its finished result until the register frees.
// Reset (synchronous, active high) empties the stack, drops any pending
// result and returns the controller to idle; slot contents are not cleared
// since slots beyond the count are never reported.
`default_nettype none

module held_note_priority_stack
  import hnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // note[6:0], velocity[13:7]
  input  wire logic [REQ_W-1:0]    s_tuser,  // req_type[1:0]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata   // held_count[4:0], any_held[5],
                                             // top_note[12:6], top_velocity[19:13]
);

  cmd_t  cmd;
  stat_t stat;

  logic [HCNT_W-1:0] out_count;
  logic              out_any;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0]  out_vel;

  hnps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hnps_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (s_tuser),
    .in_note   (s_tdata[NOTE_W-1:0]),
    .in_vel    (s_tdata[NOTE_W+VEL_W-1:NOTE_W]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_count (out_count),
    .out_any   (out_any),
    .out_note  (out_note),
    .out_vel   (out_vel)
  );

  // Pack the result beat
  assign m_tdata = {4'b0000, out_vel, out_note, out_any, out_count};

endmodule : held_note_priority_stack

`default_nettype wire
